[hw/rtl/hrs_pkg.sv]
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types and constants for the hashed request sampler.
// ----------------------------------------------------------------------------
package hrs_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);

  localparam logic [63:0] MixAdd  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d049bb133111eb;

  localparam logic [1:0] RegWarmup    = 2'd0;
  localparam logic [1:0] RegSeed      = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;

  // hash op select
  typedef enum logic [2:0] {
    HOP_INIT = 3'd0,
    HOP_MUL1 = 3'd1,
    HOP_MUL2 = 3'd2,
    HOP_NONE = 3'd3
  } hop_t;

  typedef struct packed {
    logic load;       // latch request, clear search
    logic rd_en;      // read table at search index
    logic cmp;        // compare read data with key, set found
    logic store;      // write key at entries_used
    logic mul_step;   // one partial product step
    hop_t hop;
    logic finish;     // produce result
  } hrs_cmd_t;

  typedef struct packed {
    logic scan_done;  // index reached entries_used
    logic found;
    logic mul_done;
  } hrs_stat_t;

endpackage

[hw/rtl/hrs_ram.sv]
// ----------------------------------------------------------------------------
// hrs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module hrs_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

[hw/rtl/hrs_datapath.sv]
// ----------------------------------------------------------------------------
// hrs_datapath
// Class table search, splitmix64 hash with a 16x64 multiply per step.
// ----------------------------------------------------------------------------
module hrs_datapath import hrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  hrs_cmd_t    cmd,
  output hrs_stat_t   stat,
  input  logic [63:0] sequence_req,
  input  logic [31:0] byte_count,
  input  logic [15:0] qdepth_bin,
  input  logic [14:0] locality_bin,
  input  logic        is_write,
  input  logic [31:0] warmup_count,
  input  logic [63:0] hash_seed,
  input  logic [63:0] accept_threshold,
  output logic        sampled,
  output logic        first_seen,
  output logic        table_full
);
  logic [63:0]     key;
  logic [63:0]     seq;
  logic [CntW-1:0] scan_cnt;
  logic [CntW-1:0] entries_used;
  logic            found;
  logic            full;
  logic            rd_pending;
  logic [63:0]     rdata;
  logic [63:0]     hval;
  logic [63:0]     mcand;
  logic [63:0]     mier;
  logic [63:0]     acc;
  logic [1:0]      mstep;
  logic [79:0]     pprod;
  logic [63:0]     mixin;
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;

  assign ram_we   = cmd.store && !found && (entries_used < CntW'(TableEntries));
  assign ram_addr = ram_we ? entries_used[IdxW-1:0] : scan_cnt[IdxW-1:0];

  hrs_ram #(.Width(64), .Depth(TableEntries)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.rd_en),
    .addr  (ram_addr),
    .wdata (key),
    .rdata (rdata)
  );

  assign stat.scan_done = (scan_cnt >= entries_used) && !rd_pending;
  assign stat.found     = found;
  assign stat.mul_done  = (mstep == 2'd3);

  // 16-bit slice of multiplier times 64-bit multiplicand
  assign pprod = mcand * mier[16*mstep +: 16];

  always_comb begin
    case (cmd.hop)
      HOP_MUL1: mixin = hval ^ (hval >> 30);
      HOP_MUL2: mixin = acc ^ (acc >> 27);
      default:  mixin = hval;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
      scan_cnt     <= '0;
      found        <= 1'b0;
      full         <= 1'b0;
      rd_pending   <= 1'b0;
      mstep        <= '0;
      sampled      <= 1'b0;
      first_seen   <= 1'b0;
      table_full   <= 1'b0;
    end else begin
      rd_pending <= cmd.rd_en;
      if (cmd.load) begin
        key <= {is_write, locality_bin, qdepth_bin, byte_count};
        seq <= sequence_req;
        hval <= (sequence_req ^ hash_seed ^ ({32'd0, byte_count} << 17)
                 ^ ({48'd0, qdepth_bin} << 33) ^ ({49'd0, locality_bin} << 49)
                 ^ ({63'd0, is_write} << 61)) + MixAdd;
        scan_cnt <= '0;
        found    <= 1'b0;
      end
      if (cmd.rd_en) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cmd.cmp && rdata == key) begin
        found <= 1'b1;
      end
      // full is judged before this store bumps the count
      if (cmd.store) begin
        full <= !found && (entries_used == CntW'(TableEntries));
      end
      if (cmd.store && !found && entries_used < CntW'(TableEntries)) begin
        entries_used <= entries_used + 1'b1;
      end
      if (cmd.hop == HOP_MUL1 || cmd.hop == HOP_MUL2) begin
        mcand <= mixin;
        mier  <= (cmd.hop == HOP_MUL1) ? MixMul1 : MixMul2;
        acc   <= '0;
        mstep <= '0;
      end else if (cmd.mul_step) begin
        acc   <= acc + (pprod[63:0] << (16 * mstep));
        mstep <= mstep + 1'b1;
      end
      if (cmd.finish) begin
        first_seen <= !found;
        table_full <= full;
        sampled    <= !found || (seq < {32'd0, warmup_count})
                      || ((acc ^ (acc >> 31)) <= accept_threshold);
      end
    end
  end
endmodule

[hw/rtl/hrs_ctrl.sv]
// ----------------------------------------------------------------------------
// hrs_ctrl
// Sequencer: table scan, optional store, two multi-step multiplies, result.
// ----------------------------------------------------------------------------
module hrs_ctrl import hrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  hrs_stat_t stat,
  output hrs_cmd_t  cmd,
  output logic      done
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_CMP   = 9'b000000100,
    S_STORE = 9'b000001000,
    S_LD1   = 9'b000010000,
    S_M1    = 9'b000100000,
    S_LD2   = 9'b001000000,
    S_M2    = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.hop    = HOP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.found || stat.scan_done) begin
          state_next = S_STORE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_SCAN;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_LD1;
      end
      S_LD1: begin
        cmd.hop    = HOP_MUL1;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_LD2;
      end
      S_LD2: begin
        cmd.hop    = HOP_MUL2;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
    end
  end
endmodule

[hw/rtl/hashed_request_sampler.sv]
// ----------------------------------------------------------------------------
// hashed_request_sampler
// Decides per request whether it is sampled, using a class table and a hash.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low; one result word follows
// on valid_out for a single cycle and cannot be stalled. Each request runs a
// linear scan of the class RAM (read and compare per entry, at most 64
// entries compared) and two 64x64 multiplies done as four 16x64 partial
// products each. busy drops in the result cycle, so the next request can be
// taken at the edge that ends it.
module hashed_request_sampler import hrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] sequence_req,
  input  logic [31:0] byte_count,
  input  logic [15:0] qdepth_bin,
  input  logic [14:0] locality_bin,
  input  logic        is_write,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        valid_out,
  output logic        sampled,
  output logic        first_seen,
  output logic        table_full
);
  hrs_cmd_t    cmd;
  hrs_stat_t   stat;
  logic [31:0] warmup_count;
  logic [63:0] hash_seed;
  logic [63:0] accept_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_count     <= '0;
      hash_seed        <= '0;
      accept_threshold <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegWarmup:    warmup_count     <= cfg_data[31:0];
        RegSeed:      hash_seed        <= cfg_data;
        RegThreshold: accept_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  hrs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd),
    .done  (valid_out)
  );

  hrs_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .sequence_req     (sequence_req),
    .byte_count       (byte_count),
    .qdepth_bin       (qdepth_bin),
    .locality_bin     (locality_bin),
    .is_write         (is_write),
    .warmup_count     (warmup_count),
    .hash_seed        (hash_seed),
    .accept_threshold (accept_threshold),
    .sampled          (sampled),
    .first_seen       (first_seen),
    .table_full       (table_full)
  );

`ifndef ASSERT_OFF
  a_full_new: assert property (@(posedge clk) disable iff (rst)
    valid_out && table_full |-> first_seen && sampled) else $error("full without new");
  a_new_sampled: assert property (@(posedge clk) disable iff (rst)
    valid_out && first_seen |-> sampled) else $error("new class not sampled");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> !busy) else $error("result while busy");
`endif
endmodule
